>>> hdl/pox_pkg.sv
// ----------------------------------------------------------------------------
// pox_pkg
// shared types, register codes and constants of the pulse oximeter block
// ----------------------------------------------------------------------------
package pox_pkg;

  localparam int SAMPLE_W = 24;
  localparam int GAP_W    = 20;
  localparam int RATE_W   = 16;
  localparam int PCT_W    = 7;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int MARGIN_W = 10;
  localparam int CAL_W    = 8;
  localparam int SINCE_W  = 32;

  // shared divider sizing
  localparam int DIV_W = 58;
  localparam int QUO_W = 26;
  localparam int KW    = 5;

  localparam logic [KW-1:0] BPM_K = 5'd26;
  localparam logic [KW-1:0] SPO_K = 5'd7;

  localparam logic [31:0] BPM_NUMER = 32'd120000000;
  localparam logic [RATE_W-1:0] RATE_MAX = 16'hFFFF;
  localparam logic [PCT_W-1:0]  PCT_MAX  = 7'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE   = 2'd3;

  localparam logic [23:0]         MIN_GAP_RST = 24'd100000;
  localparam logic [MARGIN_W-1:0] MARGIN_RST  = 10'd10;
  localparam logic [CAL_W-1:0]    OFFSET_RST  = 8'd110;
  localparam logic [CAL_W-1:0]    SLOPE_RST   = 8'd25;

  typedef struct packed {
    logic [SAMPLE_W-1:0] ir_sample;
    logic [SAMPLE_W-1:0] red_sample;
    logic [GAP_W-1:0]    gap_us;
  } pox_in_t;

  typedef struct packed {
    logic [RATE_W-1:0] heart_rate;
    logic [PCT_W-1:0]  oxygen_pct;
    logic              beat_taken;
  } pox_out_t;

  typedef enum logic [2:0] {
    OP_IRDC, OP_REDDC, OP_IRAC, OP_REDAC, OP_BPM, OP_SPO
  } div_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_UPDATE, ST_PREP, ST_EVAL,
    ST_DIV_IRDC, ST_DIV_REDDC, ST_DIV_IRAC, ST_DIV_REDAC, ST_DIV_BPM,
    ST_MUL1, ST_MUL2, ST_SUB, ST_DIV_SPO, ST_DONE
  } state_t;

  typedef struct packed {
    logic    load;
    logic    rd;
    logic    upd;
    logic    prep;
    logic    eval;
    logic    recip;
    logic    div_start;
    logic    capture;
    div_op_t op;
    logic    mul1;
    logic    mul2;
    logic    sub;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic beat_go;
    logic spo_skip;
    logic out_free;
  } stat_t;

endpackage

>>> hdl/pulse_oximeter_bpm_spo2_top.sv
// ----------------------------------------------------------------------------
// pulse_oximeter_bpm_spo2_top
// heart rate from ir beat timing and spo2 from the red/ir ratio of ratios
// ----------------------------------------------------------------------------
// sequence: accept, window read, sum update, prep and beat evaluation, then
//   dc and ac by one reciprocal multiply each; the one-bit-a-cycle divider
//   runs the bpm division on a beat and the spo2 division unless spo2 is zero
// one item at a time: the next item is taken only after the last result
//   is loaded into the output register, which waits while the output is stalled
// reset: synchronous, windows read as zero until written, sums, timers
//   and held rate cleared, registers back to their defaults
module pulse_oximeter_bpm_spo2_top #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  // item input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pox_pkg::pox_in_t               in_data,
  // item output
  output logic                           out_valid,
  input  logic                           out_stall,
  output pox_pkg::pox_out_t              out_data,
  // register writes
  input  logic                           cfg_we,
  input  logic [pox_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pox_pkg::CFG_W-1:0]      cfg_wdata
);

  // controller to datapath commands, datapath status back
  pox_pkg::cmd_t  cmd;
  pox_pkg::stat_t stat;

  // sequencer: one item at a time, stalls input while busy
  pox_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // windows, sums, divider and output register
  pox_dp #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

>>> hdl/pox_div.sv
// ----------------------------------------------------------------------------
// pox_div
// restoring divider, one quotient bit a cycle, k bits with overflow flag
// ----------------------------------------------------------------------------
module pox_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pox_pkg::DIV_W-1:0]  num,
  input  logic [pox_pkg::DIV_W-1:0]  den,
  input  logic [pox_pkg::KW-1:0]     k,
  output logic [pox_pkg::QUO_W-1:0]  quo,
  output logic                       ovf,
  output logic                       busy,
  output logic                       done
);

  localparam int SW = $clog2(pox_pkg::DIV_W + 1);

  logic [pox_pkg::DIV_W-1:0] rem;
  logic [pox_pkg::DIV_W-1:0] sh;
  logic [pox_pkg::KW-1:0]    cnt;
  logic [pox_pkg::DIV_W:0]   trial;
  logic                      ge;
  logic [pox_pkg::DIV_W:0]   diff;
  logic [pox_pkg::DIV_W-1:0] head;

  assign head  = num >> k;
  assign trial = {rem, sh[pox_pkg::DIV_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};
  assign done  = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= k;
      rem  <= head;
      sh   <= num << (SW'(pox_pkg::DIV_W) - SW'(k));
      quo  <= '0;
      ovf  <= head >= den;
    end else if (busy) begin
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        rem <= ge ? diff[pox_pkg::DIV_W-1:0] : trial[pox_pkg::DIV_W-1:0];
        sh  <= sh << 1;
        quo <= {quo[pox_pkg::QUO_W-2:0], ge};
      end else begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/pox_dp.sv
// ----------------------------------------------------------------------------
// pox_dp
// sample windows, running sums, beat timing and spo2 arithmetic
// ----------------------------------------------------------------------------
module pox_dp #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pox_pkg::cmd_t                   cmd,
  output pox_pkg::stat_t                  stat,
  input  pox_pkg::pox_in_t                in_data,
  output pox_pkg::pox_out_t               out_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            cfg_we,
  input  logic [pox_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pox_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int TOT_W  = pox_pkg::SAMPLE_W + $clog2(WINDOW_LEN);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);
  localparam int SW = pox_pkg::SINCE_W;
  localparam int RATE_W_L = pox_pkg::RATE_W;

  // reciprocal of the window length, exact for any value below 2^TOT_W
  localparam int RC_S = TOT_W + SLOT_W;
  localparam int RC_W = TOT_W + 1;
  localparam int RP_W = TOT_W + RC_W;
  localparam logic [RC_W-1:0] RECIP =
    RC_W'(((64'd1 << RC_S) + 64'(WINDOW_LEN - 1)) / 64'(WINDOW_LEN));

  // configuration
  logic [23:0]                     min_gap;
  logic [pox_pkg::MARGIN_W-1:0]    margin;
  logic [pox_pkg::CAL_W-1:0]       offset;
  logic [pox_pkg::CAL_W-1:0]       slope;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap <= pox_pkg::MIN_GAP_RST;
      margin  <= pox_pkg::MARGIN_RST;
      offset  <= pox_pkg::OFFSET_RST;
      slope   <= pox_pkg::SLOPE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pox_pkg::CFG_MIN_GAP: min_gap <= cfg_wdata;
        pox_pkg::CFG_MARGIN:  margin  <= cfg_wdata[pox_pkg::MARGIN_W-1:0];
        pox_pkg::CFG_OFFSET:  offset  <= cfg_wdata[pox_pkg::CAL_W-1:0];
        pox_pkg::CFG_SLOPE:   slope   <= cfg_wdata[pox_pkg::CAL_W-1:0];
        default: ;
      endcase
    end
  end

  // current item
  pox_pkg::pox_in_t cur;
  always_ff @(posedge clk) begin
    if (cmd.load) cur <= in_data;
  end

  // windows
  logic [pox_pkg::SAMPLE_W-1:0] ir_mem  [WINDOW_LEN];
  logic [pox_pkg::SAMPLE_W-1:0] red_mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]        filled;
  logic [SLOT_W-1:0]            slot;
  logic [pox_pkg::SAMPLE_W-1:0] ir_rd;
  logic [pox_pkg::SAMPLE_W-1:0] red_rd;
  logic                         rd_ok;

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      ir_mem[slot]  <= cur.ir_sample;
      red_mem[slot] <= cur.red_sample;
    end
    if (cmd.rd) begin
      ir_rd  <= ir_mem[slot];
      red_rd <= red_mem[slot];
      rd_ok  <= filled[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      slot   <= '0;
    end else if (cmd.upd) begin
      filled[slot] <= 1'b1;
      slot <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
    end
  end

  // running sums, elapsed time, beat
  logic [TOT_W-1:0]    ir_total;
  logic [TOT_W-1:0]    red_total;
  logic [SW-1:0]       since;
  logic [RATE_W_L-1:0] held;
  logic                above;
  logic                beat_go;
  logic [SW:0]         since_sum;
  logic [pox_pkg::SAMPLE_W-1:0] old_ir;
  logic [pox_pkg::SAMPLE_W-1:0] old_red;

  assign old_ir    = rd_ok ? ir_rd : '0;
  assign old_red   = rd_ok ? red_rd : '0;
  assign since_sum = {1'b0, since} + (SW+1)'(cur.gap_us);

  // prepared values
  logic [TOT_W-1:0]   ir_scaled;
  logic [TOT_W-1:0]   red_scaled;
  logic [TOT_W-1:0]   dev_ir;
  logic [TOT_W-1:0]   dev_red;
  logic [TOT_W+9:0]   lhs;
  logic [TOT_W+10:0]  rhs;
  logic               over;

  assign ir_scaled  = TOT_W'(cur.ir_sample) * TOT_W'(WINDOW_LEN);
  assign red_scaled = TOT_W'(cur.red_sample) * TOT_W'(WINDOW_LEN);
  assign over       = {1'b0, lhs} > rhs;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dev_ir  <= (ir_scaled >= ir_total) ? ir_scaled - ir_total : ir_total - ir_scaled;
      dev_red <= (red_scaled >= red_total) ? red_scaled - red_total
                                           : red_total - red_scaled;
      lhs <= {ir_scaled, 10'b0};
      rhs <= (TOT_W+11)'(ir_total) * (TOT_W+11)'({1'b0, margin} + 11'd1024);
    end
  end

  // shared divider, bpm and spo2 only
  logic [pox_pkg::DIV_W-1:0] d_num;
  logic [pox_pkg::DIV_W-1:0] d_den;
  logic [pox_pkg::KW-1:0]    d_k;
  logic [pox_pkg::QUO_W-1:0] quo;
  logic                      ovf;
  logic                      div_busy;
  logic                      div_done;
  logic [pox_pkg::DIV_W-1:0] spo_num;
  logic [pox_pkg::DIV_W-1:0] spo_den;

  always_comb begin
    d_num = pox_pkg::DIV_W'(pox_pkg::BPM_NUMER) + pox_pkg::DIV_W'(since);
    d_den = pox_pkg::DIV_W'({since, 1'b0});
    d_k   = pox_pkg::BPM_K;
    case (cmd.op)
      pox_pkg::OP_SPO: begin
        d_num = spo_num;
        d_den = spo_den;
        d_k   = pox_pkg::SPO_K;
      end
      default: ;
    endcase
  end

  pox_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (d_num),
    .den   (d_den),
    .k     (d_k),
    .quo   (quo),
    .ovf   (ovf),
    .busy  (div_busy),
    .done  (div_done)
  );

  // dc / ac by one reciprocal multiply a cycle
  logic [TOT_W-1:0]             rc_in;
  logic [RP_W-1:0]              rc_prod;
  logic [pox_pkg::SAMPLE_W-1:0] rc_quo;

  always_comb begin
    case (cmd.op)
      pox_pkg::OP_REDDC: rc_in = red_total;
      pox_pkg::OP_IRAC:  rc_in = dev_ir;
      pox_pkg::OP_REDAC: rc_in = dev_red;
      default:           rc_in = ir_total;
    endcase
  end

  assign rc_prod = RP_W'(rc_in) * RP_W'(RECIP);
  assign rc_quo  = rc_prod[RC_S +: pox_pkg::SAMPLE_W];

  // dc / ac and spo2
  logic [pox_pkg::SAMPLE_W-1:0] ir_dc;
  logic [pox_pkg::SAMPLE_W-1:0] red_dc;
  logic [pox_pkg::SAMPLE_W-1:0] ir_ac;
  logic [pox_pkg::SAMPLE_W-1:0] red_ac;
  logic [47:0]                  prod_num;
  logic [47:0]                  prod_den;
  logic                         zero;
  logic [55:0]                  pos;
  logic [55:0]                  neg;
  logic [55:0]                  pdiff;
  logic                         skip;
  logic [pox_pkg::PCT_W-1:0]    pct;

  assign pdiff = pos - neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_total  <= '0;
      red_total <= '0;
      since     <= '0;
      held      <= '0;
      above     <= 1'b0;
      beat_go   <= 1'b0;
    end else begin
      if (cmd.upd) begin
        ir_total  <= ir_total - TOT_W'(old_ir) + TOT_W'(cur.ir_sample);
        red_total <= red_total - TOT_W'(old_red) + TOT_W'(cur.red_sample);
        since     <= since_sum[SW] ? {SW{1'b1}} : since_sum[SW-1:0];
      end
      if (cmd.eval) begin
        if (over && !above) begin
          above   <= 1'b1;
          beat_go <= since > SW'(min_gap);
        end else begin
          beat_go <= 1'b0;
          if (!over) above <= 1'b0;
        end
      end
      if (cmd.capture && cmd.op == pox_pkg::OP_BPM) begin
        held  <= (|quo[pox_pkg::QUO_W-1:RATE_W_L]) ? pox_pkg::RATE_MAX
                                                   : quo[RATE_W_L-1:0];
        since <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.recip) begin
      case (cmd.op)
        pox_pkg::OP_IRDC:  ir_dc  <= rc_quo;
        pox_pkg::OP_REDDC: red_dc <= rc_quo;
        pox_pkg::OP_IRAC:  ir_ac  <= rc_quo;
        pox_pkg::OP_REDAC: red_ac <= rc_quo;
        default: ;
      endcase
    end
    if (cmd.capture) begin
      case (cmd.op)
        pox_pkg::OP_SPO:
          pct <= (ovf || quo > pox_pkg::QUO_W'(pox_pkg::PCT_MAX)) ? pox_pkg::PCT_MAX
                                                                   : quo[pox_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
    if (cmd.mul1) begin
      prod_num <= red_ac * ir_dc;
      prod_den <= red_dc * ir_ac;
      zero     <= (ir_dc == '0) || (red_dc == '0) || (ir_ac == '0);
    end
    if (cmd.mul2) begin
      pos <= 56'(offset) * 56'(prod_den);
      neg <= 56'(slope) * 56'(prod_num);
    end
    if (cmd.sub) begin
      skip    <= zero || (pos <= neg);
      spo_num <= pox_pkg::DIV_W'({pdiff, 1'b0}) + pox_pkg::DIV_W'(prod_den);
      spo_den <= pox_pkg::DIV_W'({prod_den, 1'b0});
      pct     <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.heart_rate <= held;
      out_data.oxygen_pct <= pct;
      out_data.beat_taken <= beat_go;
    end
  end

  assign stat.div_done = div_done;
  assign stat.beat_go  = beat_go;
  assign stat.spo_skip = skip;
  assign stat.out_free = !out_valid || !out_stall;

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy) else $error("divider started while busy");
  a_out_set: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid) else $error("result not presented");
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.oxygen_pct <= pox_pkg::PCT_MAX) else $error("spo2 out of range");
  a_held_stable: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.op == pox_pkg::OP_BPM) |=> $stable(held))
    else $error("rate changed without beat");

endmodule

>>> hdl/pox_ctrl.sv
// ----------------------------------------------------------------------------
// pox_ctrl
// sequencer that steps the datapath through one item
// ----------------------------------------------------------------------------
module pox_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  pox_pkg::stat_t stat,
  output pox_pkg::cmd_t  cmd
);

  pox_pkg::state_t state;
  pox_pkg::state_t state_next;
  pox_pkg::state_t after;
  logic            launched;
  logic            launched_next;
  logic            is_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pox_pkg::ST_IDLE;
      launched <= 1'b0;
    end else begin
      state    <= state_next;
      launched <= launched_next;
    end
  end

  assign in_stall = (state != pox_pkg::ST_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.op        = pox_pkg::OP_IRDC;
    state_next    = state;
    launched_next = launched;
    is_div        = 1'b0;
    after         = pox_pkg::ST_IDLE;
    case (state)
      pox_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = pox_pkg::ST_READ;
        end
      end
      pox_pkg::ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = pox_pkg::ST_UPDATE;
      end
      pox_pkg::ST_UPDATE: begin
        cmd.upd    = 1'b1;
        state_next = pox_pkg::ST_PREP;
      end
      pox_pkg::ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = pox_pkg::ST_EVAL;
      end
      pox_pkg::ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = pox_pkg::ST_DIV_IRDC;
      end
      pox_pkg::ST_DIV_IRDC: begin
        cmd.recip  = 1'b1;
        cmd.op     = pox_pkg::OP_IRDC;
        state_next = pox_pkg::ST_DIV_REDDC;
      end
      pox_pkg::ST_DIV_REDDC: begin
        cmd.recip  = 1'b1;
        cmd.op     = pox_pkg::OP_REDDC;
        state_next = pox_pkg::ST_DIV_IRAC;
      end
      pox_pkg::ST_DIV_IRAC: begin
        cmd.recip  = 1'b1;
        cmd.op     = pox_pkg::OP_IRAC;
        state_next = pox_pkg::ST_DIV_REDAC;
      end
      pox_pkg::ST_DIV_REDAC: begin
        cmd.recip  = 1'b1;
        cmd.op     = pox_pkg::OP_REDAC;
        state_next = stat.beat_go ? pox_pkg::ST_DIV_BPM : pox_pkg::ST_MUL1;
      end
      pox_pkg::ST_DIV_BPM: begin
        is_div = 1'b1;
        cmd.op = pox_pkg::OP_BPM;
        after  = pox_pkg::ST_MUL1;
      end
      pox_pkg::ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = pox_pkg::ST_MUL2;
      end
      pox_pkg::ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = pox_pkg::ST_SUB;
      end
      pox_pkg::ST_SUB: begin
        cmd.sub    = 1'b1;
        state_next = pox_pkg::ST_DIV_SPO;
      end
      pox_pkg::ST_DIV_SPO: begin
        cmd.op = pox_pkg::OP_SPO;
        after  = pox_pkg::ST_DONE;
        if (stat.spo_skip && !launched) state_next = pox_pkg::ST_DONE;
        else is_div = 1'b1;
      end
      pox_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = pox_pkg::ST_IDLE;
        end
      end
      default: state_next = pox_pkg::ST_IDLE;
    endcase

    // common launch / wait for the shared divider
    if (is_div) begin
      if (!launched) begin
        cmd.div_start = 1'b1;
        launched_next = 1'b1;
      end else if (stat.div_done) begin
        cmd.capture   = 1'b1;
        launched_next = 1'b0;
        state_next    = after;
      end
    end
  end

  a_start_once: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !cmd.div_start) else $error("divider launched twice");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == pox_pkg::ST_READ) else $error("item not started");
  a_capture_launched: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> launched) else $error("capture without launch");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the pulse oximeter: predicts heart rate, spo2 and
// beat flag per item and compares every result in order
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WLEN      = 10;
  localparam int CYCLE_CAP = 2000000;
  localparam int MAX_SHOWN = 10;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  pox_pkg::pox_in_t in_data;
  logic out_valid;
  logic out_stall;
  pox_pkg::pox_out_t out_data;
  logic cfg_we;
  logic [pox_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pox_pkg::CFG_W-1:0] cfg_wdata;

  pulse_oximeter_bpm_spo2_top #(.WINDOW_LEN(WLEN)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state, mirrors the block's windows and registers
  logic [23:0] ir_hist [WLEN];
  logic [23:0] red_hist [WLEN];
  logic [63:0] ir_sum, red_sum;
  int unsigned slot_next;
  bit was_above;
  logic [31:0] elapsed_us;
  logic [15:0] last_bpm;
  logic [23:0] gap_floor;
  logic [9:0] margin_q10;
  logic [7:0] cal_offset, cal_slope;

  pox_pkg::pox_out_t pending_results [$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned beats_seen;
  longint unsigned cycles;

  // stimulus controls
  bit send_gaps;
  bit recv_gaps;
  int hold_recv;

  function automatic logic [63:0] deviation(logic [63:0] s, logic [63:0] tot);
    logic [63:0] sc;
    sc = s * WLEN;
    return ((sc >= tot) ? sc - tot : tot - sc) / WLEN;
  endfunction

  function automatic logic [6:0] spo2_estimate(logic [63:0] iac, logic [63:0] idc,
                                               logic [63:0] rac, logic [63:0] rdc);
    logic [127:0] num, den, pos, neg, r;
    if (idc == 0 || rdc == 0 || iac == 0) return '0;
    num = rac * idc;
    den = rdc * iac;
    pos = cal_offset * den;
    neg = cal_slope * num;
    if (pos <= neg) return '0;
    r = (2 * (pos - neg) + den) / (2 * den);
    if (r > 100) r = 100;
    return r[6:0];
  endfunction

  // advance the predictor by one item and queue what the block must return
  task automatic predict_item(pox_pkg::pox_in_t it);
    pox_pkg::pox_out_t res;
    logic [63:0] idc, rdc, iac, rac, bpm;
    logic [32:0] acc;
    bit over;
    int unsigned s;
    s = (slot_next < WLEN) ? slot_next : 0;
    ir_sum = ir_sum - ir_hist[s] + it.ir_sample;
    red_sum = red_sum - red_hist[s] + it.red_sample;
    ir_hist[s] = it.ir_sample;
    red_hist[s] = it.red_sample;
    slot_next = (s + 1 >= WLEN) ? 0 : s + 1;
    acc = elapsed_us + it.gap_us;
    elapsed_us = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
    idc = ir_sum / WLEN;
    rdc = red_sum / WLEN;
    iac = deviation(it.ir_sample, ir_sum);
    rac = deviation(it.red_sample, red_sum);
    over = (64'(it.ir_sample) * WLEN * 1024) > (ir_sum * (1024 + margin_q10));
    res.beat_taken = 1'b0;
    if (over && !was_above) begin
      was_above = 1'b1;
      if (elapsed_us > gap_floor) begin
        bpm = (64'd120000000 + elapsed_us) / (2 * 64'(elapsed_us));
        if (bpm > 65535) bpm = 65535;
        last_bpm = bpm[15:0];
        elapsed_us = '0;
        res.beat_taken = 1'b1;
      end
    end else if (!over) begin
      was_above = 1'b0;
    end
    res.heart_rate = last_bpm;
    res.oxygen_pct = spo2_estimate(iac, idc, rac, rdc);
    pending_results.push_back(res);
  endtask

  // valid stays high into the next call, so items can follow back to back
  task automatic send_item(logic [23:0] ir, logic [23:0] red, logic [19:0] gap);
    pox_pkg::pox_in_t it;
    it.ir_sample = ir;
    it.red_sample = red;
    it.gap_us = gap;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  // only called while idle
  task automatic write_reg(logic [pox_pkg::CFG_IDX_W-1:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      pox_pkg::CFG_MIN_GAP: gap_floor = val;
      pox_pkg::CFG_MARGIN:  margin_q10 = val[9:0];
      pox_pkg::CFG_OFFSET:  cal_offset = val[7:0];
      pox_pkg::CFG_SLOPE:   cal_slope = val[7:0];
      default: ;
    endcase
  endtask

  // synthetic pulse: baseline with a periodic peak every few samples, plus occasional random ir values
  task automatic send_pulse_train(int n, int period, logic [23:0] base,
                                  logic [23:0] swing, logic [19:0] gap);
    logic [23:0] ir, red;
    for (int i = 0; i < n; i++) begin
      ir = (i % period == 0) ? base + swing
                             : base - 24'($urandom_range(0, swing / 8));
      red = base / 2 + 24'($urandom_range(0, swing / 2));
      if ($urandom_range(0, 9) == 0) ir = 24'($urandom);
      send_item(ir, red, 20'(gap + $urandom_range(0, gap / 4)));
    end
  endtask

  task automatic test_directed();
    send_item(24'd0, 24'd0, 20'd0);           // all dc zero
    send_item(24'hFFFFFF, 24'hFFFFFF, 20'd1000000);
    send_item(24'hFFFFFF, 24'd0, 20'hFFFFF);
    send_item(24'd0, 24'hFFFFFF, 20'd0);
    send_item(24'h555555, 24'hAAAAAA, 20'h55555);
    send_item(24'hAAAAAA, 24'h555555, 20'hAAAAA);
    for (int i = 0; i < 10; i++)              // flat signal, ir ac zero
      send_item(24'd500000, 24'd300000, 20'd10000);
    send_item(24'd900000, 24'd310000, 20'd900000); // rising crossing, beat
    send_item(24'd950000, 24'd320000, 20'd900000); // still above, no beat
    send_item(24'd400000, 24'd300000, 20'd1000);
    send_item(24'd990000, 24'd330000, 20'd5000);   // crossing past min gap, beat
    send_item(24'd1, 24'd1, 20'd1);
    drain();
  endtask

  task automatic test_registers();
    // extremes: small gap floor, zero margin, wide calibration
    write_reg(pox_pkg::CFG_MIN_GAP, 24'd1000);
    write_reg(pox_pkg::CFG_MARGIN, 24'd0);
    write_reg(pox_pkg::CFG_OFFSET, 24'd255);
    write_reg(pox_pkg::CFG_SLOPE, 24'd0);
    send_pulse_train(60, 4, 24'd200000, 24'd50000, 20'd400);
    drain();
    write_reg(pox_pkg::CFG_MIN_GAP, 24'd10000000);
    write_reg(pox_pkg::CFG_MARGIN, 24'd1023);
    write_reg(pox_pkg::CFG_OFFSET, 24'd0);
    write_reg(pox_pkg::CFG_SLOPE, 24'd255);
    send_pulse_train(40, 5, 24'd100000, 24'd200000, 20'd1000000);
    drain();
    write_reg(pox_pkg::CFG_MIN_GAP, 24'hFFFFFF);       // largest gap floor
    write_reg(pox_pkg::CFG_MARGIN, 24'h3FF);
    write_reg(pox_pkg::CFG_OFFSET, 24'hFF);
    write_reg(pox_pkg::CFG_SLOPE, 24'hFF);
    send_pulse_train(20, 3, 24'd8000000, 24'd8000000, 20'd1000000);
    drain();
    write_reg(pox_pkg::CFG_MIN_GAP, pox_pkg::MIN_GAP_RST);
    write_reg(pox_pkg::CFG_MARGIN, 24'(pox_pkg::MARGIN_RST));
    write_reg(pox_pkg::CFG_OFFSET, 24'(pox_pkg::OFFSET_RST));
    write_reg(pox_pkg::CFG_SLOPE, 24'(pox_pkg::SLOPE_RST));
  endtask

  task automatic test_random();
    for (int k = 0; k < 16; k++) begin
      send_pulse_train(40, int'($urandom_range(2, 12)),
                       24'($urandom_range(1000, 8000000)),
                       24'($urandom_range(1, 8000000)),
                       20'($urandom_range(0, 300000)));
      if (k % 4 == 3) begin
        drain();
        write_reg(pox_pkg::CFG_MIN_GAP, 24'($urandom_range(1000, 2000000)));
        write_reg(pox_pkg::CFG_MARGIN, 24'($urandom_range(0, 1023)));
        write_reg(pox_pkg::CFG_OFFSET, 24'($urandom_range(0, 255)));
        write_reg(pox_pkg::CFG_SLOPE, 24'($urandom_range(0, 255)));
      end
    end
    for (int i = 0; i < 120; i++)             // noise over the full sample ranges
      send_item(24'($urandom), 24'($urandom), 20'($urandom_range(0, 1000000)));
  endtask

  task automatic test_backpressure();
    // long receiver hold while the sender keeps offering items
    hold_recv = 2000;
    send_pulse_train(20, 4, 24'd300000, 24'd90000, 20'd20000);
    drain();
  endtask

  task automatic test_no_idling();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    send_pulse_train(100, 6, 24'd600000, 24'd150000, 20'd40000);
    drain();
  endtask

  // receiver side: random stall bursts, plus a long hold when asked
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_recv > 0) begin
      hold_recv <= hold_recv - 1;
      out_stall <= 1'b1;
    end else if (out_stall) begin
      out_stall <= ($urandom_range(0, 2) != 0) && recv_gaps;
    end else begin
      out_stall <= recv_gaps && ($urandom_range(0, 4) == 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    pox_pkg::pox_out_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.beat_taken) beats_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected item: rate %0d spo2 %0d beat %0d",
                   out_data.heart_rate, out_data.oxygen_pct, out_data.beat_taken);
      end else begin
        want = pending_results.pop_front();
        if (want !== out_data) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("item %0d: expected rate %0d spo2 %0d beat %0d, got %0d %0d %0d",
                     results_seen, want.heart_rate, want.oxygen_pct, want.beat_taken,
                     out_data.heart_rate, out_data.oxygen_pct, out_data.beat_taken);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("** pulse_oximeter_bpm_spo2_top: FAILED **");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_recv = 0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    mismatches = 0;
    results_seen = 0;
    beats_seen = 0;
    cycles = 0;
    for (int i = 0; i < WLEN; i++) begin
      ir_hist[i] = '0;
      red_hist[i] = '0;
    end
    ir_sum = '0;
    red_sum = '0;
    slot_next = 0;
    was_above = 1'b0;
    elapsed_us = '0;
    last_bpm = '0;
    gap_floor = pox_pkg::MIN_GAP_RST;
    margin_q10 = pox_pkg::MARGIN_RST;
    cal_offset = pox_pkg::OFFSET_RST;
    cal_slope = pox_pkg::SLOPE_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_registers();
    test_random();
    test_backpressure();
    test_no_idling();
    drain();

    $display("covered %0d results with %0d accepted beats over register extremes,",
             results_seen, beats_seen);
    $display("random pulse trains, full-range noise, long output hold and no idling");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** pulse_oximeter_bpm_spo2_top: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("** pulse_oximeter_bpm_spo2_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/pox_pkg.sv
hdl/pox_div.sv
hdl/pox_dp.sv
hdl/pox_ctrl.sv
hdl/pulse_oximeter_bpm_spo2_top.sv
test/tb_top.sv
